[rtl/ffpa_pkg.sv]
// shared types and constants for the first-fit partition allocator
package ffpa_pkg;
	localparam int MAX_BLOCKS = 32;
	localparam int IDX_BITS = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
	localparam int OWNERS = 16;
	localparam int OWN_BITS = 4;
	localparam int AW = 16;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic action;
		logic [OWN_BITS-1:0] owner_id;
		logic [AW-1:0] amount;
		logic free_all;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [AW-1:0] start_address;
		logic [AW-1:0] owner_total;
	} rsp_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
		logic [OWN_BITS-1:0] owner;
		logic used;
	} entry_t;
endpackage

[rtl/first_fit_partition_allocator.sv]
// top level: first-fit partition allocator with sequencer over the partition table
//
// Channels: req (valid/stall, req_t payload) and rsp (valid/stall, rsp_t payload).
// A request is a transfer on req; exactly one response follows on rsp.
// memory_size_we/memory_size write the managed size and restart the table:
// the write is taken only while idle, req_stall is high in that cycle; one table
// entry is rebuilt and the owner totals are cleared in the same cycle.
// Sequence: a bad request answers in the cycle after its transfer. Otherwise the
// table is scanned one entry per cycle, a split shifts entries up one per cycle,
// then the update states write the table (APUT or FPUT, FPRV when a freed piece
// joins the previous free entry, PUT2 for the split piece), then a merge pass
// reads and shifts entries, alternating MRD and MSH. The single table write
// port sets this sequence.
// One request is in service at a time; req_stall stays high until the
// response transfer completes, and the next request is taken in the cycle after it.
// The response register holds while rsp_stall.
// Reset (arst_n low) gives one free partition of 65535 units, totals zero;
// the table entry is written in the INIT state after reset, with req_stall high.
module first_fit_partition_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic memory_size_we,
	input  logic [15:0] memory_size,
	input  logic req_valid,
	output logic req_stall,
	input  ffpa_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output ffpa_pkg::rsp_t rsp
);
	import ffpa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_SHUP = 4'd2;
	localparam logic [3:0] S_APUT = 4'd3;
	localparam logic [3:0] S_FPUT = 4'd4;
	localparam logic [3:0] S_MRD = 4'd5;
	localparam logic [3:0] S_MSH = 4'd6;
	localparam logic [3:0] S_RSP = 4'd7;
	localparam logic [3:0] S_FPRV = 4'd8;
	localparam logic [3:0] S_PUT2 = 4'd9;
	localparam logic [3:0] S_INIT = 4'd10;

	logic [3:0] state_q;
	req_t req_q;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] i_q;
	logic [IDX_BITS-1:0] hit_q;
	logic [IDX_BITS-1:0] dst_q;
	entry_t hit_e_q;
	entry_t prev_e_q;
	logic prev_free_q;
	logic [AW-1:0] held_q [OWNERS];
	logic [AW-1:0] msize_q;

	// second write for split pieces, held here and done in the PUT2 sequence state
	logic put2_q;
	entry_t put2_e_q;
	logic [IDX_BITS-1:0] put2_a_q;

	logic we;
	logic [IDX_BITS-1:0] waddr, raddr;
	entry_t wdata, rdata;

	ffpa_table u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [AW-1:0] len;
	logic [AW-1:0] rest;
	logic [AW:0] held_sum;
	logic match;
	logic full;
	logic [AW-1:0] cur_held;

	assign cur_held = held_q[req_q.owner_id];
	assign len = req_q.free_all ? hit_e_q.size : req_q.amount;
	assign rest = hit_e_q.size - len;
	assign held_sum = {1'b0, cur_held} + {1'b0, req_q.amount};
	assign full = count_q >= CNT_BITS'(MAX_BLOCKS);
	assign match = req_q.action ? (rdata.used && rdata.owner == req_q.owner_id &&
		(req_q.free_all || rdata.size >= req_q.amount)) :
		(!rdata.used && rdata.size >= req_q.amount);

	assign req_stall = state_q != S_IDLE || memory_size_we;

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = i_q[IDX_BITS-1:0];
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				wdata = '{start: '0, size: msize_q, owner: '0, used: 1'b0};
			end
			S_IDLE: begin
				if (memory_size_we) begin
					we = 1'b1;
					wdata = '{start: '0, size: memory_size, owner: '0, used: 1'b0};
				end
			end
			S_SHUP: begin
				raddr = i_q[IDX_BITS-1:0] - IDX_BITS'(1);
				we = i_q > CNT_BITS'(put2_a_q);
				waddr = i_q[IDX_BITS-1:0];
				wdata = rdata;
			end
			S_APUT: begin
				we = 1'b1;
				waddr = hit_q;
				wdata = '{start: hit_e_q.start, size: req_q.amount,
					owner: req_q.owner_id, used: 1'b1};
			end
			S_FPUT: begin
				if (rest == '0 || put2_q) begin
					we = 1'b1;
					waddr = hit_q;
					wdata = '{start: hit_e_q.start, size: len, owner: '0, used: 1'b0};
				end
			end
			S_FPRV: begin
				we = 1'b1;
				waddr = hit_q - IDX_BITS'(1);
				wdata = prev_e_q;
				wdata.size = prev_e_q.size + len;
			end
			S_PUT2: begin
				we = 1'b1;
				waddr = put2_a_q;
				wdata = put2_e_q;
			end
			S_MRD: begin
				if (i_q != '0 && i_q >= count_q) begin
					we = 1'b1;
					waddr = dst_q;
					wdata = prev_e_q;
				end
			end
			S_MSH: begin
				if (prev_e_q.used || rdata.used) begin
					we = 1'b1;
					waddr = dst_q;
					wdata = prev_e_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			rsp_valid <= 1'b0;
			count_q <= CNT_BITS'(1);
			msize_q <= '1;
			put2_q <= 1'b0;
			for (int k = 0; k < OWNERS; k++) held_q[k] <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (memory_size_we) begin
						msize_q <= memory_size;
						count_q <= CNT_BITS'(1);
						for (int k = 0; k < OWNERS; k++) held_q[k] <= '0;
					end else if (req_valid) begin
						req_q <= req;
						i_q <= '0;
						if (req.action ? (!req.free_all && req.amount == '0) :
							(req.amount == '0)) begin
							rsp.status <= ST_BAD;
							rsp.start_address <= '0;
							rsp.owner_total <= held_q[req.owner_id];
							rsp_valid <= 1'b1;
							state_q <= S_RSP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (i_q >= count_q) begin
						rsp.status <= ST_NOFIT;
						rsp.start_address <= '0;
						rsp.owner_total <= cur_held;
						rsp_valid <= 1'b1;
						state_q <= S_RSP;
					end else if (match) begin
						hit_q <= i_q[IDX_BITS-1:0];
						hit_e_q <= rdata;
						prev_free_q <= !prev_e_q.used && i_q != '0;
						if (!req_q.action) begin
							if (rdata.size != req_q.amount) begin
								if (full) begin
									rsp.status <= ST_FULL;
									rsp.start_address <= '0;
									rsp.owner_total <= cur_held;
									rsp_valid <= 1'b1;
									state_q <= S_RSP;
								end else begin
									put2_q <= 1'b1;
									put2_a_q <= i_q[IDX_BITS-1:0] + IDX_BITS'(1);
									put2_e_q <= '{start: rdata.start + req_q.amount,
										size: rdata.size - req_q.amount,
										owner: '0, used: 1'b0};
									i_q <= count_q;
									count_q <= count_q + CNT_BITS'(1);
									state_q <= S_SHUP;
								end
							end else begin
								state_q <= S_APUT;
							end
						end else begin
							state_q <= S_FPUT;
						end
					end else begin
						prev_e_q <= rdata;
						i_q <= i_q + CNT_BITS'(1);
					end
				end
				S_SHUP: begin
					if (i_q > CNT_BITS'(put2_a_q)) begin
						i_q <= i_q - CNT_BITS'(1);
					end else begin
						state_q <= req_q.action ? S_FPUT : S_APUT;
					end
				end
				S_APUT: begin
					state_q <= put2_q ? S_PUT2 : S_MRD;
					i_q <= '0;
					held_q[req_q.owner_id] <= held_sum[AW] ? '1 : held_sum[AW-1:0];
					rsp.status <= ST_OK;
					rsp.start_address <= hit_e_q.start;
					rsp.owner_total <= held_sum[AW] ? '1 : held_sum[AW-1:0];
				end
				S_FPUT: begin
					if (rest != '0 && !prev_free_q && !put2_q) begin
						if (full) begin
							rsp.status <= ST_FULL;
							rsp.start_address <= '0;
							rsp.owner_total <= cur_held;
							rsp_valid <= 1'b1;
							state_q <= S_RSP;
						end else begin
							// freed piece goes at hit, used rest moves to hit+1
							put2_q <= 1'b1;
							put2_a_q <= hit_q + IDX_BITS'(1);
							put2_e_q <= '{start: hit_e_q.start + len, size: rest,
								owner: hit_e_q.owner, used: 1'b1};
							i_q <= count_q;
							count_q <= count_q + CNT_BITS'(1);
							state_q <= S_SHUP;
						end
					end else begin
						if (rest != '0 && prev_free_q) begin
							put2_q <= 1'b1;
							put2_a_q <= hit_q;
							put2_e_q <= '{start: hit_e_q.start + len, size: rest,
								owner: hit_e_q.owner, used: 1'b1};
							state_q <= S_FPRV;
						end else begin
							state_q <= put2_q ? S_PUT2 : S_MRD;
						end
						i_q <= '0;
						held_q[req_q.owner_id] <= cur_held > len ? cur_held - len : '0;
						rsp.status <= ST_OK;
						rsp.start_address <= hit_e_q.start;
						rsp.owner_total <= cur_held > len ? cur_held - len : '0;
					end
				end
				S_FPRV: begin
					state_q <= S_PUT2;
				end
				S_PUT2: begin
					state_q <= S_MRD;
				end
				S_MRD: begin
					// merge: i_q scans, dst_q is last kept entry
					if (i_q == '0) begin
						dst_q <= '0;
						prev_e_q <= rdata;
						i_q <= CNT_BITS'(1);
					end else if (i_q >= count_q) begin
						count_q <= CNT_BITS'(dst_q) + CNT_BITS'(1);
						rsp_valid <= 1'b1;
						state_q <= S_RSP;
					end else begin
						state_q <= S_MSH;
					end
				end
				S_MSH: begin
					i_q <= i_q + CNT_BITS'(1);
					state_q <= S_MRD;
					if (!prev_e_q.used && !rdata.used) begin
						prev_e_q.size <= prev_e_q.size + rdata.size;
					end else begin
						dst_q <= dst_q + IDX_BITS'(1);
						prev_e_q <= rdata;
					end
				end
				S_RSP: begin
					put2_q <= 1'b0;
					if (!rsp_stall) begin
						rsp_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp));
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall);
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNT_BITS'(MAX_BLOCKS));
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= S_INIT);
endmodule

[rtl/ffpa_table.sv]
// partition table storage with one write port and one combinational read port
module ffpa_table (
	input  logic clk,
	input  logic we,
	input  logic [ffpa_pkg::IDX_BITS-1:0] waddr,
	input  ffpa_pkg::entry_t wdata,
	input  logic [ffpa_pkg::IDX_BITS-1:0] raddr,
	output ffpa_pkg::entry_t rdata
);
	import ffpa_pkg::*;

	entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_comb begin
		rdata = mem[raddr];
	end
endmodule
